>>> hdl/dasre_pkg.sv
// Shared types and constants for the data access stride run encoder.
package dasre_pkg;

    localparam int ADDR_BITS   = 64;
    localparam int FIELD_ADDR_W = 64;
    localparam int LEN_W       = 32;
    localparam int STRIDE_W    = 16;
    localparam int TOTAL_W     = 64;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] RUN_MAX = {LEN_W{1'b1}};

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_END    = 1'b1;
    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_SUM   = 1'b1;

    typedef enum logic {
        BP_RUN,
        BP_SUM
    } t_bphase;

    typedef struct packed {
        logic                       has_run;
        logic                       has_sum;
        logic [ADDR_BITS-1:0]       start_addr;
        logic [LEN_W-1:0]           run_length;
        logic signed [STRIDE_W-1:0] stride;
        logic [1:0]                 size_code;
        logic                       wr_flag;
        logic [TOTAL_W-1:0]         total_accesses;
        logic [TOTAL_W-1:0]         total_runs;
    } t_rec;

    typedef struct packed {
        logic                       kind;
        logic [FIELD_ADDR_W-1:0]    start_addr;
        logic [LEN_W-1:0]           run_length;
        logic signed [STRIDE_W-1:0] stride;
        logic [1:0]                 size_code;
        logic                       wr_flag;
        logic [TOTAL_W-1:0]         total_accesses;
        logic [TOTAL_W-1:0]         total_runs;
        logic                       last;
    } t_beat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

>>> hdl/dasre_front.sv
// Front end: accepts accesses, tracks the pending run and queues finished records.
module dasre_front import dasre_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic                    i_valid,
    input  logic                    i_cmd,
    input  logic [FIELD_ADDR_W-1:0] i_address,
    input  logic [1:0]              i_size_code,
    input  logic                    i_is_write,
    input  t_qstat                  i_qstat,
    output logic                    o_stall,
    output logic                    o_push,
    output t_rec                    o_push_rec
);

    logic                       r_enable, n_enable;
    logic [ADDR_BITS-1:0]       r_first, n_first;
    logic [LEN_W-1:0]           r_count, n_count;
    logic signed [STRIDE_W-1:0] r_stride, n_stride;
    logic [1:0]                 r_size, n_size;
    logic                       r_write, n_write;
    logic [ADDR_BITS-1:0]       r_prev, n_prev;
    logic [TOTAL_W-1:0]         r_acc_total, n_acc_total;
    logic [TOTAL_W-1:0]         r_run_total, n_run_total;

    logic                       w_accept;
    logic [ADDR_BITS-1:0]       w_addr;
    logic signed [ADDR_BITS:0]  w_diff;
    logic                       w_fits;
    logic                       w_same;
    logic                       w_has_run;

    assign o_stall   = i_qstat.full;
    assign w_accept  = i_valid && !i_qstat.full;
    assign w_addr    = i_address[ADDR_BITS-1:0];
    assign w_diff    = $signed({1'b0, w_addr}) - $signed({1'b0, r_prev});
    assign w_fits    = (&w_diff[ADDR_BITS:STRIDE_W-1]) || !(|w_diff[ADDR_BITS:STRIDE_W-1]);
    assign w_same    = (r_size == i_size_code) && (r_write == i_is_write);
    assign w_has_run = (r_count != '0);

    always_comb begin
        n_enable    = r_enable;
        n_first     = r_first;
        n_count     = r_count;
        n_stride    = r_stride;
        n_size      = r_size;
        n_write     = r_write;
        n_prev      = r_prev;
        n_acc_total = r_acc_total;
        n_run_total = r_run_total;
        o_push      = 1'b0;

        o_push_rec                = '0;
        o_push_rec.has_run        = w_has_run;
        o_push_rec.start_addr     = r_first;
        o_push_rec.run_length     = r_count;
        o_push_rec.stride         = r_stride;
        o_push_rec.size_code      = r_size;
        o_push_rec.wr_flag        = r_write;

        if (i_cfg_we) begin
            n_enable = i_cfg_wdata;
        end else if (w_accept && r_enable) begin
            if (i_cmd == CMD_END) begin
                o_push                    = 1'b1;
                o_push_rec.has_sum        = 1'b1;
                o_push_rec.total_accesses = r_acc_total;
                o_push_rec.total_runs     = r_run_total + TOTAL_W'(w_has_run);
                n_run_total = r_run_total + TOTAL_W'(w_has_run);
                n_count     = '0;
                n_first     = '0;
                n_stride    = '0;
                n_size      = '0;
                n_write     = 1'b0;
                n_enable    = 1'b0;
            end else begin
                n_acc_total = r_acc_total + TOTAL_W'(1);
                if (!w_has_run) begin
                    n_first  = w_addr;
                    n_count  = LEN_W'(1);
                    n_stride = '0;
                    n_size   = i_size_code;
                    n_write  = i_is_write;
                    n_prev   = w_addr;
                end else if (r_count == LEN_W'(1) && w_fits && w_same) begin
                    n_stride = w_diff[STRIDE_W-1:0];
                    n_count  = LEN_W'(2);
                    n_prev   = w_addr;
                end else if (w_fits && w_same && w_diff[STRIDE_W-1:0] == r_stride
                             && r_count != RUN_MAX) begin
                    n_count = r_count + LEN_W'(1);
                    n_prev  = w_addr;
                end else begin
                    o_push      = 1'b1;
                    n_run_total = r_run_total + TOTAL_W'(1);
                    n_first     = w_addr;
                    n_count     = LEN_W'(1);
                    n_stride    = '0;
                    n_size      = i_size_code;
                    n_write     = i_is_write;
                    n_prev      = w_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_first     <= '0;
            r_count     <= '0;
            r_stride    <= '0;
            r_size      <= '0;
            r_write     <= 1'b0;
            r_prev      <= '0;
            r_acc_total <= '0;
            r_run_total <= '0;
        end else begin
            r_enable    <= n_enable;
            r_first     <= n_first;
            r_count     <= n_count;
            r_stride    <= n_stride;
            r_size      <= n_size;
            r_write     <= n_write;
            r_prev      <= n_prev;
            r_acc_total <= n_acc_total;
            r_run_total <= n_run_total;
        end
    end

    a_push_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_push_rec.has_run || o_push_rec.has_sum))
        else $error("queued record carries nothing");

    a_end_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_rec.has_sum && !i_cfg_we) |=> !r_enable && r_count == '0)
        else $error("end of trace left recording on or a run pending");

endmodule

>>> hdl/dasre_fifo.sv
// Short record queue between the front end and the output sequencer.
module dasre_fifo import dasre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_push_rec,
    input  logic   i_pop,
    output t_rec   o_head,
    output t_qstat o_qstat
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + QPTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("pop from empty queue");

endmodule

>>> hdl/dasre_back.sv
// Output sequencer: turns queued records into one or two output beats.
module dasre_back import dasre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_rec   i_head,
    input  t_qstat i_qstat,
    input  logic   i_stall,
    output logic   o_pop,
    output logic   o_valid,
    output t_beat  o_beat
);

    t_bphase r_phase, n_phase;
    logic    r_valid, n_valid;
    t_beat   r_beat, n_beat;
    logic    w_load;
    t_beat   w_run_beat;
    t_beat   w_sum_beat;

    assign w_load  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_comb begin
        w_run_beat                = '0;
        w_run_beat.kind           = KIND_RUN;
        w_run_beat.start_addr     = FIELD_ADDR_W'(i_head.start_addr);
        w_run_beat.run_length     = i_head.run_length;
        w_run_beat.stride         = i_head.stride;
        w_run_beat.size_code      = i_head.size_code;
        w_run_beat.wr_flag        = i_head.wr_flag;
        w_run_beat.last           = !i_head.has_sum;

        w_sum_beat                = '0;
        w_sum_beat.kind           = KIND_SUM;
        w_sum_beat.total_accesses = i_head.total_accesses;
        w_sum_beat.total_runs     = i_head.total_runs;
        w_sum_beat.last           = 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_valid = r_valid && i_stall;
        n_beat  = r_beat;
        o_pop   = 1'b0;
        if (w_load && !i_qstat.empty) begin
            n_valid = 1'b1;
            case (r_phase)
                BP_RUN: begin
                    if (i_head.has_run) begin
                        n_beat = w_run_beat;
                        if (i_head.has_sum) begin
                            n_phase = BP_SUM;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end else begin
                        n_beat = w_sum_beat;
                        o_pop  = 1'b1;
                    end
                end
                BP_SUM: begin
                    n_beat  = w_sum_beat;
                    o_pop   = 1'b1;
                    n_phase = BP_RUN;
                end
                default: n_phase = BP_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= BP_RUN;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    a_sum_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat.kind == KIND_SUM) |-> o_beat.last)
        else $error("summary beat without last");

    a_sum_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == BP_SUM) |-> (!i_qstat.empty && i_head.has_sum))
        else $error("summary phase without a summary record at the head");

endmodule

>>> hdl/data_access_stride_run_encoder.sv
// Top level of the data access stride run encoder.
// Each finished record is written into the record queue at the edge that accepts the input
// beat that closes it; the output register is then loaded from the queue head.
// Throughput: one input beat per cycle; input stalls only while the 4-entry record queue
// is full. An end command yields up to two output beats, the run beat and then the summary.
// Reset (synchronous, active low) clears recording enable, the pending run, totals,
// the queue and the output valid.
module data_access_stride_run_encoder import dasre_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_cmd,
    input  logic [FIELD_ADDR_W-1:0]    i_address,
    input  logic [1:0]                 i_size_code,
    input  logic                       i_is_write,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_kind,
    output logic [FIELD_ADDR_W-1:0]    o_first_address,
    output logic [LEN_W-1:0]           o_run_length,
    output logic signed [STRIDE_W-1:0] o_stride,
    output logic [1:0]                 o_run_size_code,
    output logic                       o_run_is_write,
    output logic [TOTAL_W-1:0]         o_total_accesses,
    output logic [TOTAL_W-1:0]         o_total_runs,
    output logic                       o_last
);

    t_qstat w_qstat;
    logic   w_push;
    t_rec   w_push_rec;
    logic   w_pop;
    t_rec   w_head;
    t_beat  w_beat;

    dasre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_address   (i_address),
        .i_size_code (i_size_code),
        .i_is_write  (i_is_write),
        .i_qstat     (w_qstat),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_push_rec  (w_push_rec)
    );

    dasre_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_rec (w_push_rec),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_qstat    (w_qstat)
    );

    dasre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .i_stall (i_stall),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_beat  (w_beat)
    );

    assign o_kind           = w_beat.kind;
    assign o_first_address  = w_beat.start_addr;
    assign o_run_length     = w_beat.run_length;
    assign o_stride         = w_beat.stride;
    assign o_run_size_code  = w_beat.size_code;
    assign o_run_is_write   = w_beat.wr_flag;
    assign o_total_accesses = w_beat.total_accesses;
    assign o_total_runs     = w_beat.total_runs;
    assign o_last           = w_beat.last;

endmodule

>>> dv/data_access_stride_run_encoder_tb.sv
// Self-checking testbench for the data access stride run encoder.
module data_access_stride_run_encoder_tb import dasre_pkg::*; ();

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 125;
    localparam int TIMEOUT_UNITS = CLK_PERIOD * 400000;

    class stride_run_tracker;
        logic              enable;
        logic [63:0]       first_addr;
        logic [63:0]       prev_addr;
        logic [31:0]       count;
        logic [15:0]       stride;
        logic [1:0]        size;
        logic              wr;
        logic [63:0]       acc_seen;
        logic [63:0]       runs_seen;
        t_beat             pending_records[$];
        int                errors;

        function new();
            enable       = 1'b0;
            first_addr   = '0;
            prev_addr    = '0;
            count        = '0;
            stride       = '0;
            size         = '0;
            wr           = 1'b0;
            acc_seen     = '0;
            runs_seen    = '0;
            errors       = 0;
        endfunction

        function void set_enable(logic v);
            enable = v;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        function void close_run(logic is_last);
            t_beat b;
            if (count == 0) return;
            b               = '0;
            b.kind          = KIND_RUN;
            b.start_addr    = first_addr;
            b.run_length    = count;
            b.stride        = stride;
            b.size_code     = size;
            b.wr_flag       = wr;
            b.last          = is_last;
            pending_records.push_back(b);
            runs_seen  = runs_seen + 1;
            count      = '0;
            first_addr = '0;
            stride     = '0;
            size       = '0;
            wr         = 1'b0;
        endfunction

        function void open_run(logic [63:0] a, logic [1:0] sz, logic w);
            first_addr = a;
            count      = 32'd1;
            stride     = '0;
            size       = sz;
            wr         = w;
            prev_addr  = a;
        endfunction

        function void note_access(logic cmd, logic [63:0] a_in, logic [1:0] sz, logic w);
            logic [63:0] mask;
            logic [63:0] a;
            logic [63:0] d;
            logic [15:0] step;
            logic        fits;
            logic        same;
            t_beat       b;
            mask = ~64'd0 >> (64 - ADDR_BITS);
            if (!enable) return;
            if (cmd == CMD_END) begin
                close_run(1'b0);
                b                = '0;
                b.kind           = KIND_SUM;
                b.total_accesses = acc_seen;
                b.total_runs     = runs_seen;
                b.last           = 1'b1;
                pending_records.push_back(b);
                enable = 1'b0;
                return;
            end
            a = a_in & mask;
            acc_seen = acc_seen + 1;
            if (count == 0) begin
                open_run(a, sz, w);
                return;
            end
            if (a >= prev_addr) begin
                d    = a - prev_addr;
                fits = (d <= 64'd32767);
                step = d[15:0];
            end else begin
                d    = prev_addr - a;
                fits = (d <= 64'd32768);
                step = 16'h0 - d[15:0];
            end
            same = (size == sz) && (wr == w);
            if (count == 1 && fits && same) begin
                stride    = step;
                count     = 32'd2;
                prev_addr = a;
                return;
            end
            if (fits && same && step == stride && count != RUN_MAX) begin
                count     = count + 1;
                prev_addr = a;
                return;
            end
            close_run(1'b1);
            open_run(a, sz, w);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_record(t_beat got);
            t_beat exp_b;
            if (pending_records.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            exp_b = pending_records.pop_front();
            compare_field("o_kind", 64'(exp_b.kind), 64'(got.kind));
            compare_field("o_first_address", exp_b.start_addr, got.start_addr);
            compare_field("o_run_length", 64'(exp_b.run_length), 64'(got.run_length));
            compare_field("o_stride", 64'(exp_b.stride), 64'(got.stride));
            compare_field("o_run_size_code", 64'(exp_b.size_code), 64'(got.size_code));
            compare_field("o_run_is_write", 64'(exp_b.wr_flag), 64'(got.wr_flag));
            compare_field("o_total_accesses", exp_b.total_accesses, got.total_accesses);
            compare_field("o_total_runs", exp_b.total_runs, got.total_runs);
            compare_field("o_last", 64'(exp_b.last), 64'(got.last));
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_wdata;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_cmd;
    logic [FIELD_ADDR_W-1:0]    i_address;
    logic [1:0]                 i_size_code;
    logic                       i_is_write;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_kind;
    logic [FIELD_ADDR_W-1:0]    o_first_address;
    logic [LEN_W-1:0]           o_run_length;
    logic signed [STRIDE_W-1:0] o_stride;
    logic [1:0]                 o_run_size_code;
    logic                       o_run_is_write;
    logic [TOTAL_W-1:0]         o_total_accesses;
    logic [TOTAL_W-1:0]         o_total_runs;
    logic                       o_last;

    stride_run_tracker sb;
    int                idle_pct;
    int                stall_pct;
    int                live_items;

    data_access_stride_run_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_address        (i_address),
        .i_size_code      (i_size_code),
        .i_is_write       (i_is_write),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_first_address  (o_first_address),
        .o_run_length     (o_run_length),
        .o_stride         (o_stride),
        .o_run_size_code  (o_run_size_code),
        .o_run_is_write   (o_run_is_write),
        .o_total_accesses (o_total_accesses),
        .o_total_runs     (o_total_runs),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("data_access_stride_run_encoder_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_beat got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (sb.enable) live_items++;
                sb.note_access(i_cmd, i_address, i_size_code, i_is_write);
            end
            if (o_valid && !i_stall) begin
                got.kind           = o_kind;
                got.start_addr     = o_first_address;
                got.run_length     = o_run_length;
                got.stride         = o_stride;
                got.size_code      = o_run_size_code;
                got.wr_flag        = o_run_is_write;
                got.total_accesses = o_total_accesses;
                got.total_runs     = o_total_runs;
                got.last           = o_last;
                sb.check_record(got);
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [63:0] a, input logic [1:0] sz,
                             input logic w);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_address   <= a;
        i_size_code <= sz;
        i_is_write  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_access(input logic [63:0] a, input logic [1:0] sz, input logic w);
        send_beat(CMD_ACCESS, a, sz, w);
    endtask

    task automatic send_end();
        send_beat(CMD_END, {$urandom, $urandom}, 2'($urandom), 1'($urandom));
    endtask

    // let every expected beat arrive, then give the pipeline time to empty
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_enable(v);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_run();
        logic [63:0]        a;
        logic signed [63:0] step;
        logic signed [15:0] s16;
        logic [1:0]         sz;
        logic               w;
        int                 len;
        sz  = 2'($urandom);
        w   = 1'($urandom);
        len = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: a = {$urandom, $urandom};
            1: a = 64'($urandom_range(0, 65535));
            2: a = 64'h0 - 64'($urandom_range(1, 65536));
            default: a = {32'h0, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0: step = 64'sd32767;
            1: step = -64'sd32768;
            2: step = 64'sd0;
            3: begin
                s16  = 16'($urandom);
                step = s16;
            end
            4: step = $urandom_range(0, 1) ? 64'sd32768 : -64'sd32769;
            default: begin
                step = 64'sd1 << sz;
                if ($urandom_range(0, 1)) step = -step;
            end
        endcase
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8) begin
                case ($urandom_range(0, 2))
                    0: send_access(a, sz + 2'd1, w);
                    1: send_access(a, sz, ~w);
                    default: send_access({$urandom, $urandom}, sz, w);
                endcase
            end else begin
                send_access(a, sz, w);
            end
            a = a + step;
        end
    endtask

    task automatic random_phase(input int idle_p, input int stall_p);
        int sel;
        idle_pct   = idle_p;
        stall_pct  = stall_p;
        live_items = 0;
        while (live_items < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                send_run();
            end else if (sel < 84) begin
                send_access({$urandom, $urandom}, 2'($urandom), 1'($urandom));
            end else if (sel < 92) begin
                send_end();
                repeat ($urandom_range(0, 2))
                    send_access({$urandom, $urandom}, 2'($urandom), 1'($urandom));
                settle();
                cfg_write(1'b1);
            end else if (sel < 96) begin
                settle();
                cfg_write(1'b0);
                repeat ($urandom_range(1, 3))
                    send_beat(1'($urandom), {$urandom, $urandom}, 2'($urandom),
                              1'($urandom));
                settle();
                cfg_write(1'b1);
            end else begin
                settle();
            end
        end
        send_end();
        settle();
        cfg_write(1'b1);
    endtask

    initial begin
        sb          = new();
        idle_pct    = 0;
        stall_pct   = 0;
        live_items  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_cmd       = CMD_ACCESS;
        i_address   = '0;
        i_size_code = '0;
        i_is_write  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // input before any enable write is ignored
        send_access(64'h1234, 2'd0, 1'b0);
        settle();
        cfg_write(1'b1);

        idle_pct  = 30;
        stall_pct = 30;
        // most negative stride, then a step just out of range
        send_access(64'h1_0000, 2'd3, 1'b0);
        send_access(64'h0_8000, 2'd3, 1'b0);
        send_access(64'h0, 2'd3, 1'b0);
        send_access(64'h0_8000, 2'd3, 1'b0);
        // most positive stride, then a step just below the negative limit
        send_access(64'h0_FFFF, 2'd3, 1'b0);
        send_access(64'h1_7FFE, 2'd3, 1'b0);
        send_access(64'h0_FFFD, 2'd3, 1'b0);
        // shape change at the second access
        send_access(64'h1_0005, 2'd2, 1'b0);
        send_access(64'h1_000D, 2'd2, 1'b1);
        // top of the address space, stride -1, then zero stride
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 2'd1, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFE, 2'd1, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFD, 2'd1, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFD, 2'd1, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFD, 2'd1, 1'b1);
        send_end();
        // ignored after end
        send_access(64'h40, 2'd0, 1'b0);
        send_end();
        settle();
        cfg_write(1'b1);
        // end with no pending run
        send_end();
        settle();
        cfg_write(1'b0);
        send_access(64'h80, 2'd1, 1'b1);
        send_end();
        settle();
        cfg_write(1'b1);
        send_access(64'h0, 2'd0, 1'b0);
        send_access(64'h1, 2'd1, 1'b1);
        send_access(64'h3, 2'd2, 1'b0);
        send_access(64'h7, 2'd3, 1'b1);
        send_end();
        settle();
        cfg_write(1'b1);

        random_phase(0, 0);
        random_phase(78, 0);
        random_phase(0, 78);
        random_phase(18, 18);

        stall_pct = 0;
        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("data_access_stride_run_encoder_tb OK");
        end else begin
            $display("data_access_stride_run_encoder_tb NOT OK");
        end
        $finish;
    end
endmodule

>>> data_access_stride_run_encoder.f
hdl/dasre_pkg.sv
hdl/dasre_front.sv
hdl/dasre_fifo.sv
hdl/dasre_back.sv
hdl/data_access_stride_run_encoder.sv
dv/data_access_stride_run_encoder_tb.sv
